### rtl/tic_pkg.sv
// Package: constants, opcodes, fault codes and shared types for the teaching ISA core.
`default_nettype none
package tic_pkg;
    localparam int MEM_BYTES_DEF = 1024;

    localparam logic [3:0] OP_HALT = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_AND  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_MUL  = 4'd4;
    localparam logic [3:0] OP_SUB  = 4'd5;
    localparam logic [3:0] OP_OR   = 4'd6;
    localparam logic [3:0] OP_STK  = 4'd7;
    localparam logic [3:0] OP_INT  = 4'd8;
    localparam logic [3:0] OP_ADDI = 4'd9;
    localparam logic [3:0] OP_BEQ  = 4'd10;
    localparam logic [3:0] OP_BLT  = 4'd11;
    localparam logic [3:0] OP_JMP  = 4'd12;
    localparam logic [3:0] OP_CALL = 4'd13;
    localparam logic [3:0] OP_LD   = 4'd14;
    localparam logic [3:0] OP_ST   = 4'd15;

    localparam logic [1:0] STK_RET  = 2'd0;
    localparam logic [1:0] STK_PUSH = 2'd1;
    localparam logic [1:0] STK_POP  = 2'd2;

    localparam logic [1:0] FLT_NONE = 2'd0;
    localparam logic [1:0] FLT_MEM  = 2'd1;
    localparam logic [1:0] FLT_DIV0 = 2'd2;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

### rtl/teaching_isa_cpu_core.sv
// Top level: sequencer, register file and shared ALU of the teaching ISA core.
// A byte load or a PC past memory is answered straight from idle; otherwise the
// instruction is fetched byte by byte (the first byte sets its length, and one cut off
// by the end of memory halts with a memory fault), then addressed and executed, with
// words loaded and stored a byte at a time and a divide waiting on the bit-serial divider.
// One request at a time; the next is accepted in the cycle the result is taken. Reset
// (aresetn, synchronous): registers and PC cleared; memory is not cleared.
`default_nettype none
module teaching_isa_cpu_core
    import tic_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_action,
    input  wire logic [9:0]         s_load_address,
    input  wire logic [7:0]         s_load_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_next_pc,
    output logic        [3:0]       m_opcode_done,
    output logic                    m_reg_written,
    output logic        [3:0]       m_reg_index,
    output logic signed [31:0]      m_reg_value,
    output logic                    m_mem_written,
    output logic        [9:0]       m_mem_address,
    output logic        [31:0]      m_mem_word,
    output logic                    m_halted,
    output logic        [7:0]       m_interrupt_code,
    output logic                    m_interrupt_raised,
    output logic        [1:0]       m_fault
);
    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [32:0] MEMSZ = 33'(MEM_BYTES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FETCH = 4'd1;
    localparam logic [3:0] S_EXEC  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_WR    = 4'd5;
    localparam logic [3:0] S_DONE  = 4'd6;
    localparam logic [3:0] S_ADDR  = 4'd8;

    logic [3:0]  st_reg;
    logic [31:0] rf_reg [16];
    logic [31:0] pc_reg;
    logic [31:0] ibuf_reg;
    logic [2:0]  cnt_reg;
    logic [2:0]  len_reg;
    logic [31:0] addr_reg;
    logic [31:0] data_reg;
    logic        rdv_reg;
    logic        div_start_reg;

    // result register
    logic        ov_reg;
    logic [31:0] o_pc_reg, o_rv_reg, o_mw_reg;
    logic [3:0]  o_op_reg, o_ri_reg;
    logic        o_rw_reg, o_mwr_reg, o_h_reg, o_ir_reg;
    logic [9:0]  o_ma_reg;
    logic [7:0]  o_ic_reg;
    logic [1:0]  o_f_reg;

    // memory port
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata, mem_rdata;

    div_req_t dreq;
    div_rsp_t drsp;

    tic_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .aclk(aclk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
    );

    tic_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    logic [7:0]  b0, b1, b2, b3;
    logic [3:0]  op, ra, rb, rd;
    logic [31:0] x, y, alu_a, alu_b, alu_sum;
    logic        alu_sub;
    logic [1:0]  sub;

    assign b0 = ibuf_reg[31:24];
    assign b1 = ibuf_reg[23:16];
    assign b2 = ibuf_reg[15:8];
    assign b3 = ibuf_reg[7:0];
    assign op = b0[7:4];
    assign ra = b0[3:0];
    assign rb = b1[7:4];
    assign rd = b1[3:0];
    assign sub = b1[7:6];
    assign x = rf_reg[ra];
    assign y = rf_reg[rb];

    // shared adder
    assign alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    function automatic logic word_ok(input logic [31:0] a);
        return ({1'b0, a} + 33'd4) <= MEMSZ;
    endfunction

    assign s_ready = (st_reg == S_IDLE) && (!ov_reg || m_ready);
    logic acc;
    assign acc = s_valid && s_ready;

    // write data for the byte port comes from the word buffer, or from the request for a load
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = ibuf_reg[31:24];
        mem_addr  = addr_reg[AW-1:0];
        if (acc && !s_action) begin
            mem_we    = s_load_address < 10'(MEM_BYTES > 1023 ? 1023 : MEM_BYTES)
                        || (MEM_BYTES > 1023);
            mem_addr  = AW'(s_load_address);
            mem_wdata = s_load_byte;
        end else if (st_reg == S_WR) begin
            mem_we = 1'b1;
        end
    end

    always_comb begin
        alu_a = x;
        alu_b = y;
        alu_sub = 1'b0;
        case (op)
            OP_SUB, OP_BLT: alu_sub = 1'b1;
            OP_ADDI: alu_b = {{24{b1[7]}}, b1};
            OP_STK, OP_CALL: begin
                alu_a = rf_reg[15];
                alu_b = 32'd4;
                alu_sub = !(op == OP_STK && sub != STK_PUSH);
            end
            OP_LD, OP_ST: begin
                alu_a = y;
                alu_b = {27'd0, rd, 1'b0};
            end
            default: ;
        endcase
        if (st_reg == S_ADDR) begin
            alu_a = pc_reg;
            alu_b = (op == OP_BEQ || op == OP_BLT)
                    ? {{11{b1[3]}}, b1[3:0], b2, b3, 1'b0} + 32'd4
                    : {29'd0, len_reg};
            alu_sub = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            pc_reg <= '0;
            ov_reg <= 1'b0;
            rdv_reg <= 1'b0;
            div_start_reg <= 1'b0;
            for (int i = 0; i < 16; i++) rf_reg[i] <= '0;
        end else begin
            div_start_reg <= 1'b0;
            rdv_reg <= 1'b0;
            if (ov_reg && m_ready) ov_reg <= 1'b0;
            case (st_reg)
                S_IDLE: if (acc) begin
                    o_pc_reg <= pc_reg; o_op_reg <= OP_HALT; o_rw_reg <= 1'b0;
                    o_ri_reg <= '0; o_rv_reg <= '0; o_mwr_reg <= 1'b0;
                    o_ma_reg <= '0; o_mw_reg <= '0; o_h_reg <= 1'b0;
                    o_ic_reg <= '0; o_ir_reg <= 1'b0; o_f_reg <= FLT_NONE;
                    if (!s_action) begin
                        if ({22'd0, s_load_address} >= MEM_BYTES) o_f_reg <= FLT_MEM;
                        ov_reg <= 1'b1;
                    end else if ({1'b0, pc_reg} >= MEMSZ) begin
                        o_h_reg <= 1'b1;
                        ov_reg <= 1'b1;
                    end else begin
                        addr_reg <= pc_reg;
                        cnt_reg <= 3'd0;
                        len_reg <= 3'd2;
                        rdv_reg <= 1'b1;
                        st_reg <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    // each byte is taken once rdv_reg has dropped after its read; first byte sets the length
                    if (!rdv_reg) begin
                        ibuf_reg <= {ibuf_reg[23:0], mem_rdata};
                        if (cnt_reg == 3'd0 && mem_rdata[7:4] >= OP_BEQ
                            && mem_rdata[7:4] <= OP_CALL) len_reg <= 3'd4;
                        if (cnt_reg == 3'd0 && ({1'b0, pc_reg} + ((mem_rdata[7:4] >= OP_BEQ
                            && mem_rdata[7:4] <= OP_CALL) ? 33'd4 : 33'd2)) > MEMSZ) begin
                            o_h_reg <= 1'b1; o_f_reg <= FLT_MEM;
                            ov_reg <= 1'b1; st_reg <= S_IDLE;
                        end else if (cnt_reg + 3'd1 == ((cnt_reg == 3'd0) ?
                            ((mem_rdata[7:4] >= OP_BEQ && mem_rdata[7:4] <= OP_CALL)
                             ? 3'd4 : 3'd2) : len_reg)) begin
                            if (len_reg == 3'd2 && cnt_reg == 3'd1)
                                ibuf_reg <= {ibuf_reg[7:0], mem_rdata, 16'd0};
                            st_reg <= S_ADDR;
                        end else begin
                            cnt_reg <= cnt_reg + 3'd1;
                            addr_reg <= addr_reg + 32'd1;
                            rdv_reg <= 1'b1;
                        end
                    end
                end
                S_ADDR: begin
                    // default next PC and, for a branch, the target used when it is taken
                    data_reg <= pc_reg + {29'd0, len_reg};
                    addr_reg <= alu_sum;
                    o_op_reg <= op;
                    st_reg <= S_EXEC;
                end
                S_EXEC: begin
                    st_reg <= S_DONE;
                    case (op)
                        OP_HALT: begin
                            data_reg <= pc_reg; o_h_reg <= 1'b1;
                        end
                        OP_ADD, OP_SUB, OP_AND, OP_OR, OP_MUL: begin
                            o_rw_reg <= 1'b1; o_ri_reg <= rd;
                            o_rv_reg <= (op == OP_AND) ? (x & y) : (op == OP_OR) ? (x | y)
                                      : (op == OP_MUL) ? (x * y) : alu_sum;
                            rf_reg[rd] <= (op == OP_AND) ? (x & y) : (op == OP_OR) ? (x | y)
                                        : (op == OP_MUL) ? (x * y) : alu_sum;
                        end
                        OP_DIV: begin
                            o_rw_reg <= 1'b1; o_ri_reg <= rd;
                            if (y == 32'd0) begin
                                o_f_reg <= FLT_DIV0; o_rv_reg <= '0; rf_reg[rd] <= '0;
                            end else begin
                                div_start_reg <= 1'b1; st_reg <= S_DIV;
                            end
                        end
                        OP_INT: begin
                            o_ic_reg <= b1; o_ir_reg <= 1'b1;
                        end
                        OP_ADDI: begin
                            o_rw_reg <= 1'b1; o_ri_reg <= ra; o_rv_reg <= alu_sum;
                            rf_reg[ra] <= alu_sum;
                        end
                        OP_BEQ, OP_BLT: begin
                            if ((op == OP_BEQ) ? (x == y) : ($signed(x) < $signed(y)))
                                data_reg <= addr_reg;
                        end
                        OP_JMP: data_reg <= {3'd0, ra, b1, b2, b3, 1'b0};
                        OP_CALL: begin
                            if (!word_ok(alu_sum)) begin
                                o_f_reg <= FLT_MEM;
                            end else begin
                                rf_reg[15] <= alu_sum;
                                o_rw_reg <= 1'b1; o_ri_reg <= 4'd15; o_rv_reg <= alu_sum;
                                o_mwr_reg <= 1'b1; o_ma_reg <= alu_sum[9:0];
                                o_mw_reg <= data_reg;
                                addr_reg <= alu_sum; cnt_reg <= 3'd0;
                                data_reg <= {3'd0, ra, b1, b2, b3, 1'b0};
                                ibuf_reg <= data_reg; st_reg <= S_WR;
                            end
                        end
                        OP_STK: begin
                            if (sub == STK_PUSH) begin
                                if (!word_ok(alu_sum)) o_f_reg <= FLT_MEM;
                                else begin
                                    rf_reg[15] <= alu_sum;
                                    o_rw_reg <= 1'b1; o_ri_reg <= 4'd15; o_rv_reg <= alu_sum;
                                    o_mwr_reg <= 1'b1; o_ma_reg <= alu_sum[9:0];
                                    o_mw_reg <= (ra == 4'd15) ? alu_sum : x;
                                    ibuf_reg <= (ra == 4'd15) ? alu_sum : x;
                                    addr_reg <= alu_sum; cnt_reg <= 3'd0; st_reg <= S_WR;
                                end
                            end else if (sub == STK_RET || sub == STK_POP) begin
                                if (!word_ok(rf_reg[15])) o_f_reg <= FLT_MEM;
                                else begin
                                    addr_reg <= rf_reg[15]; cnt_reg <= 3'd0;
                                    rdv_reg <= 1'b1; st_reg <= S_RD;
                                end
                            end
                        end
                        default: begin
                            if (!word_ok(alu_sum)) o_f_reg <= FLT_MEM;
                            else if (op == OP_LD) begin
                                addr_reg <= alu_sum; cnt_reg <= 3'd0;
                                rdv_reg <= 1'b1; st_reg <= S_RD;
                            end else begin
                                o_mwr_reg <= 1'b1; o_ma_reg <= alu_sum[9:0]; o_mw_reg <= x;
                                ibuf_reg <= x; addr_reg <= alu_sum;
                                cnt_reg <= 3'd0; st_reg <= S_WR;
                            end
                        end
                    endcase
                end
                S_DIV: if (drsp.done) begin
                    o_rv_reg <= drsp.quotient; rf_reg[rd] <= drsp.quotient;
                    st_reg <= S_DONE;
                end
                S_WR: begin
                    // ibuf holds the word; write big-endian, one byte a cycle
                    data_reg <= data_reg;
                    ibuf_reg <= {ibuf_reg[23:0], 8'd0};
                    addr_reg <= addr_reg + 32'd1;
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd3) st_reg <= S_DONE;
                end
                S_RD: begin
                    if (!rdv_reg) begin
                        o_mw_reg <= {o_mw_reg[23:0], mem_rdata};
                        if (cnt_reg == 3'd3) begin
                            o_mw_reg <= '0;
                            o_rw_reg <= 1'b1;
                            if (op == OP_LD || sub == STK_POP) begin
                                o_ri_reg <= ra;
                                o_rv_reg <= {o_mw_reg[23:0], mem_rdata};
                                if (op != OP_LD) rf_reg[15] <= addr_reg + 32'd1;
                                rf_reg[ra] <= {o_mw_reg[23:0], mem_rdata};
                            end else begin
                                o_ri_reg <= 4'd15;
                                o_rv_reg <= addr_reg + 32'd1;
                                rf_reg[15] <= addr_reg + 32'd1;
                                data_reg <= {o_mw_reg[23:0], mem_rdata};
                            end
                            st_reg <= S_DONE;
                        end else begin
                            cnt_reg <= cnt_reg + 3'd1;
                            addr_reg <= addr_reg + 32'd1;
                            rdv_reg <= 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    pc_reg <= data_reg;
                    o_pc_reg <= data_reg;
                    ov_reg <= 1'b1;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // divider operands come straight from the register file
    always_comb begin
        dreq.start    = div_start_reg;
        dreq.dividend = x;
        dreq.divisor  = y;
    end

    assign m_valid = ov_reg;
    assign m_next_pc = o_pc_reg;
    assign m_opcode_done = o_op_reg;
    assign m_reg_written = o_rw_reg;
    assign m_reg_index = o_ri_reg;
    assign m_reg_value = o_rv_reg;
    assign m_mem_written = o_mwr_reg;
    assign m_mem_address = o_ma_reg;
    assign m_mem_word = o_mw_reg;
    assign m_halted = o_h_reg;
    assign m_interrupt_code = o_ic_reg;
    assign m_interrupt_raised = o_ir_reg;
    assign m_fault = o_f_reg;
endmodule
`default_nettype wire

### rtl/tic_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module tic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### rtl/tic_div.sv
// Iterative signed divider, one quotient bit per cycle.
`default_nettype none
module tic_div
    import tic_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[31]};
        trial     = shifted - {1'b0, dvs_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd31;
            rem_next  = '0;
            quo_next  = req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
            dvs_next  = req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
            neg_next  = req.dividend[31] ^ req.divisor[31];
        end else if (busy_reg) begin
            if (!trial[32]) begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;
endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the teaching ISA core: directed table, random programs, then an end-of-memory sequence.
`default_nettype none
module tb;
    import tic_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_SIZE   = 1024;
    localparam int ITEM_GOAL  = 1850;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 60;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [3:0]  opcode;
        logic        reg_w;
        logic [3:0]  reg_idx;
        logic [31:0] reg_val;
        logic        mem_w;
        logic [9:0]  mem_addr;
        logic [31:0] mem_word;
        logic        halted;
        logic [7:0]  int_code;
        logic        int_raised;
        logic [1:0]  fault;
    } step_result_t;

    typedef struct {
        logic        act;
        logic [9:0]  adr;
        logic [7:0]  dat;
        bit          chk;
        logic [31:0] pc;
        logic        halted;
        logic [1:0]  fault;
        bit          chk_rv;
        logic [31:0] rval;
    } drow_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_action = 1'b0;
    logic [9:0] s_load_address = '0;
    logic [7:0] s_load_byte = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_next_pc;
    logic [3:0] m_opcode_done;
    logic m_reg_written;
    logic [3:0] m_reg_index;
    logic signed [31:0] m_reg_value;
    logic m_mem_written;
    logic [9:0] m_mem_address;
    logic [31:0] m_mem_word;
    logic m_halted;
    logic [7:0] m_interrupt_code;
    logic m_interrupt_raised;
    logic [1:0] m_fault;

    teaching_isa_cpu_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_load_address(s_load_address), .s_load_byte(s_load_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_next_pc(m_next_pc),
        .m_opcode_done(m_opcode_done), .m_reg_written(m_reg_written),
        .m_reg_index(m_reg_index), .m_reg_value(m_reg_value),
        .m_mem_written(m_mem_written), .m_mem_address(m_mem_address),
        .m_mem_word(m_mem_word), .m_halted(m_halted),
        .m_interrupt_code(m_interrupt_code), .m_interrupt_raised(m_interrupt_raised),
        .m_fault(m_fault)
    );

    always #1 aclk = ~aclk;

    // predictor state
    logic [7:0]  prog_mem [MEM_SIZE];
    bit          prog_written [MEM_SIZE];
    logic [31:0] gpr [16];
    logic [31:0] cpu_pc;

    step_result_t pending_steps[$];
    int  mismatches = 0;
    int  items_sent = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    int  ready_hold = 0;
    drow_t dir_rows [21];

    function automatic bit word_in_range(logic [31:0] a);
        return ({1'b0, a} + 33'd4) <= 33'(MEM_SIZE);
    endfunction

    function automatic logic [31:0] read_word(logic [31:0] a);
        logic [31:0] v;
        v = '0;
        for (int j = 0; j < 4; j++) v = {v[23:0], prog_mem[a[9:0] + 10'(j)]};
        return v;
    endfunction

    function automatic void write_word(logic [31:0] a, logic [31:0] v);
        for (int j = 0; j < 4; j++) begin
            prog_mem[a[9:0] + 10'(j)] = v[31 - 8*j -: 8];
            prog_written[a[9:0] + 10'(j)] = 1'b1;
        end
    endfunction

    function automatic logic [31:0] signed_quotient(logic [31:0] x, logic [31:0] y);
        logic [31:0] ux, uy, q;
        ux = x[31] ? -x : x;
        uy = y[31] ? -y : y;
        q = ux / uy;
        return (x[31] != y[31]) ? -q : q;
    endfunction

    function automatic step_result_t predict_step(logic act, logic [9:0] adr, logic [7:0] dat);
        step_result_t r;
        logic [7:0] b0, b1, b2, b3;
        logic [3:0] op, ra, rb;
        logic [1:0] sub;
        logic [31:0] npc, x, y, v, a, off, tgt, sp;
        int len;
        r = '0;
        b2 = '0;
        b3 = '0;
        if (!act) begin
            prog_mem[adr] = dat;
            prog_written[adr] = 1'b1;
            r.next_pc = cpu_pc;
            return r;
        end
        if (cpu_pc >= MEM_SIZE) begin
            r.next_pc = cpu_pc;
            r.halted = 1'b1;
            return r;
        end
        b0 = prog_mem[cpu_pc[9:0]];
        op = b0[7:4];
        len = (op >= OP_BEQ && op <= OP_CALL) ? 4 : 2;
        if (cpu_pc + len > MEM_SIZE) begin
            r.next_pc = cpu_pc;
            r.halted = 1'b1;
            r.fault = FLT_MEM;
            return r;
        end
        b1 = prog_mem[cpu_pc[9:0] + 10'd1];
        if (len == 4) begin
            b2 = prog_mem[cpu_pc[9:0] + 10'd2];
            b3 = prog_mem[cpu_pc[9:0] + 10'd3];
        end
        npc = cpu_pc + len;
        r.opcode = op;
        ra = b0[3:0];
        rb = b1[7:4];
        case (op)
            OP_HALT: begin
                npc = cpu_pc;
                r.halted = 1'b1;
            end
            OP_ADD, OP_AND, OP_DIV, OP_MUL, OP_SUB, OP_OR: begin
                x = gpr[ra];
                y = gpr[rb];
                v = '0;
                case (op)
                    OP_ADD: v = x + y;
                    OP_AND: v = x & y;
                    OP_DIV: begin
                        if (y == 0) r.fault = FLT_DIV0;
                        else v = signed_quotient(x, y);
                    end
                    OP_MUL: v = x * y;
                    OP_SUB: v = x - y;
                    default: v = x | y;
                endcase
                gpr[b1[3:0]] = v;
                r.reg_w = 1'b1;
                r.reg_idx = b1[3:0];
                r.reg_val = v;
            end
            OP_STK: begin
                sub = b1[7:6];
                sp = gpr[15];
                if (sub == STK_RET || sub == STK_POP) begin
                    if (!word_in_range(sp)) begin
                        r.fault = FLT_MEM;
                    end else begin
                        v = read_word(sp);
                        gpr[15] = sp + 4;
                        r.reg_w = 1'b1;
                        if (sub == STK_RET) begin
                            npc = v;
                            r.reg_idx = 4'd15;
                            r.reg_val = sp + 4;
                        end else begin
                            gpr[ra] = v;
                            r.reg_idx = ra;
                            r.reg_val = v;
                        end
                    end
                end else if (sub == STK_PUSH) begin
                    a = sp - 4;
                    if (!word_in_range(a)) begin
                        r.fault = FLT_MEM;
                    end else begin
                        gpr[15] = a;
                        v = gpr[ra];
                        write_word(a, v);
                        r.reg_w = 1'b1;
                        r.reg_idx = 4'd15;
                        r.reg_val = a;
                        r.mem_w = 1'b1;
                        r.mem_addr = a[9:0];
                        r.mem_word = v;
                    end
                end
            end
            OP_INT: begin
                r.int_code = b1;
                r.int_raised = 1'b1;
            end
            OP_ADDI: begin
                v = gpr[ra] + {{24{b1[7]}}, b1};
                gpr[ra] = v;
                r.reg_w = 1'b1;
                r.reg_idx = ra;
                r.reg_val = v;
            end
            OP_BEQ, OP_BLT: begin
                x = gpr[ra];
                y = gpr[rb];
                off = {{12{b1[3]}}, b1[3:0], b2, b3};
                if (op == OP_BEQ ? (x == y) : ($signed(x) < $signed(y)))
                    npc = npc + (off << 1);
            end
            OP_JMP, OP_CALL: begin
                tgt = {b0[3:0], b1, b2, b3, 1'b0};
                if (op == OP_CALL) begin
                    a = gpr[15] - 4;
                    if (word_in_range(a)) begin
                        gpr[15] = a;
                        write_word(a, npc);
                        r.reg_w = 1'b1;
                        r.reg_idx = 4'd15;
                        r.reg_val = a;
                        r.mem_w = 1'b1;
                        r.mem_addr = a[9:0];
                        r.mem_word = npc;
                        npc = tgt;
                    end else begin
                        r.fault = FLT_MEM;
                    end
                end else begin
                    npc = tgt;
                end
            end
            default: begin
                a = gpr[rb] + {b1[3:0], 1'b0};
                if (!word_in_range(a)) begin
                    r.fault = FLT_MEM;
                end else if (op == OP_LD) begin
                    v = read_word(a);
                    gpr[ra] = v;
                    r.reg_w = 1'b1;
                    r.reg_idx = ra;
                    r.reg_val = v;
                end else begin
                    v = gpr[ra];
                    write_word(a, v);
                    r.mem_w = 1'b1;
                    r.mem_addr = a[9:0];
                    r.mem_word = v;
                end
            end
        endcase
        cpu_pc = npc;
        r.next_pc = npc;
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // hold valid across back-to-back requests; drop it only for a real gap
    task automatic drive_request(logic act, logic [9:0] adr, logic [7:0] dat);
        int g;
        g = calm ? 0 : gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_load_address <= adr;
        s_load_byte <= dat;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_request(logic act, logic [9:0] adr, logic [7:0] dat);
        pending_steps.push_back(predict_step(act, adr, dat));
        drive_request(act, adr, dat);
    endtask

    task automatic load_word(logic [31:0] a, logic [31:0] v);
        for (int j = 0; j < 4; j++) send_request(1'b0, a[9:0] + 10'(j), v[31 - 8*j -: 8]);
    endtask

    task automatic fill_unwritten(logic [31:0] a);
        for (int j = 0; j < 4; j++)
            if (!prog_written[a[9:0] + 10'(j)])
                send_request(1'b0, a[9:0] + 10'(j), 8'($urandom));
    endtask

    function automatic logic [3:0] dest_reg();
        logic [3:0] r;
        r = 4'($urandom_range(0, 14));
        return (r == 4'd14) ? 4'd15 : r;  // r14 stays zero as a fixed base
    endfunction

    function automatic logic [31:0] safe_target();
        return 32'($urandom_range(32, 500)) << 1;
    endfunction

    function automatic logic [31:0] pick_value(logic [3:0] rd);
        int p;
        p = $urandom_range(0, 9);
        if (rd == 4'd15 && p < 6) return 32'($urandom_range(100, 500)) << 1;
        case (p)
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5, 6: return 32'($urandom_range(0, 1023));
            default: return $urandom;
        endcase
    endfunction

    task automatic run_instruction();
        logic [7:0] b [4];
        logic [3:0] op, ra, rb, rd;
        logic [31:0] a, t, sp;
        logic [1:0] sub;
        int len, kind, k;
        len = 2;
        b[1] = 8'($urandom);
        b[2] = 8'($urandom);
        b[3] = 8'($urandom);
        kind = $urandom_range(0, 99);
        if (cpu_pc < 64 || cpu_pc > 1000) kind = 70;
        ra = 4'($urandom);
        rb = 4'($urandom);
        if (kind < 12) begin
            // load a chosen value through the r14 base
            rd = dest_reg();
            k = $urandom_range(0, 13);
            load_word(32'(2*k), pick_value(rd));
            b[0] = {OP_LD, rd};
            b[1] = {4'd14, 4'(k)};
        end else if (kind < 36) begin
            op = 4'($urandom_range(1, 6));
            if ($urandom_range(0, 3) == 0) rb = ra;
            b[0] = {op, ra};
            b[1] = {rb, dest_reg()};
        end else if (kind < 50) begin
            sub = 2'($urandom);
            sp = gpr[15];
            if (sub == STK_POP) ra = dest_reg();
            if (word_in_range(sp)) begin
                if (sub == STK_RET) begin
                    if (sp < cpu_pc + 2 && sp + 4 > cpu_pc) sub = 2'd3;
                    else load_word(sp, safe_target());
                end else if (sub == STK_POP) begin
                    fill_unwritten(sp);
                end
            end
            b[0] = {OP_STK, ra};
            b[1] = {sub, b[1][5:0]};
        end else if (kind < 54) begin
            b[0] = {OP_INT, ra};
        end else if (kind < 62) begin
            b[0] = {OP_ADDI, dest_reg()};
        end else if (kind < 70) begin
            op = $urandom_range(0, 1) ? OP_BEQ : OP_BLT;
            if ($urandom_range(0, 2) == 0) rb = ra;
            t = (safe_target() - (cpu_pc + 4)) >>> 1;
            len = 4;
            b[0] = {op, ra};
            b[1] = {rb, t[19:16]};
            b[2] = t[15:8];
            b[3] = t[7:0];
        end else if (kind < 80) begin
            op = (kind < 75 || cpu_pc < 64 || cpu_pc > 1000) ? OP_JMP : OP_CALL;
            t = safe_target() >> 1;
            len = 4;
            b[0] = {op, t[27:24]};
            b[1] = t[23:16];
            b[2] = t[15:8];
            b[3] = t[7:0];
        end else if (kind < 94) begin
            op = $urandom_range(0, 1) ? OP_LD : OP_ST;
            if (op == OP_LD) ra = dest_reg();
            if ($urandom_range(0, 2) == 0) rb = 4'd14;
            a = gpr[rb] + {b[1][3:0], 1'b0};
            if (op == OP_LD && word_in_range(a)) fill_unwritten(a);
            b[0] = {op, ra};
            b[1] = {rb, b[1][3:0]};
        end else if (kind < 96) begin
            b[0] = {OP_HALT, ra};
        end else begin
            send_request(1'b0, 10'($urandom), 8'($urandom));
            return;
        end
        for (int i = 0; i < len; i++) send_request(1'b0, cpu_pc[9:0] + 10'(i), b[i]);
        send_request(1'b1, 10'($urandom), 8'($urandom));
    endtask

    // receiver side: random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 25) ready_hold <= gap_len();
        end
    end

    always @(posedge aclk) begin
        step_result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_next_pc, m_opcode_done, m_reg_written, m_reg_index, m_reg_value,
                    m_mem_written, m_mem_address, m_mem_word, m_halted,
                    m_interrupt_code, m_interrupt_raised, m_fault};
            if (pending_steps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %h", got);
            end else begin
                want = pending_steps.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  pc exp %h act %h  op exp %0d act %0d",
                                 want.next_pc, got.next_pc, want.opcode, got.opcode);
                        $display("  reg exp %b/%0d/%h act %b/%0d/%h", want.reg_w,
                                 want.reg_idx, want.reg_val, got.reg_w, got.reg_idx, got.reg_val);
                        $display("  mem exp %b/%h/%h act %b/%h/%h", want.mem_w,
                                 want.mem_addr, want.mem_word, got.mem_w, got.mem_addr,
                                 got.mem_word);
                        $display("  halt/int/fault exp %b/%b/%h/%0d act %b/%b/%h/%0d",
                                 want.halted, want.int_raised, want.int_code, want.fault,
                                 got.halted, got.int_raised, got.int_code, got.fault);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        step_result_t r;
        logic [31:0] t;
        for (int i = 0; i < MEM_SIZE; i++) begin
            prog_mem[i] = '0;
            prog_written[i] = 1'b0;
        end
        for (int i = 0; i < 16; i++) gpr[i] = '0;
        cpu_pc = '0;

        dir_rows = '{
            '{1'b0, 10'd0,    8'h00, 1'b1, 32'd0,  1'b0, FLT_NONE, 1'b0, 32'd0},
            '{1'b0, 10'd1,    8'hFF, 1'b0, 32'd0,  1'b0, FLT_NONE, 1'b0, 32'd0},
            '{1'b1, 10'd0,    8'h00, 1'b1, 32'd0,  1'b1, FLT_NONE, 1'b0, 32'd0},
            '{1'b0, 10'd0,    8'h8F, 1'b0, 32'd0,  1'b0, FLT_NONE, 1'b0, 32'd0},
            '{1'b1, 10'h3FF,  8'hFF, 1'b1, 32'd2,  1'b0, FLT_NONE, 1'b0, 32'd0},
            '{1'b0, 10'd2,    8'h30, 1'b0, 32'd0,  1'b0, FLT_NONE, 1'b0, 32'd0},
            '{1'b0, 10'd3,    8'h01, 1'b0, 32'd0,  1'b0, FLT_NONE, 1'b0, 32'd0},
            '{1'b1, 10'd0,    8'h00, 1'b1, 32'd4,  1'b0, FLT_DIV0, 1'b1, 32'd0},
            '{1'b0, 10'd4,    8'h92, 1'b0, 32'd0,  1'b0, FLT_NONE, 1'b0, 32'd0},
            '{1'b0, 10'd5,    8'h7F, 1'b0, 32'd0,  1'b0, FLT_NONE, 1'b0, 32'd0},
            '{1'b1, 10'd0,    8'h00, 1'b1, 32'd6,  1'b0, FLT_NONE, 1'b1, 32'd127},
            '{1'b0, 10'd6,    8'h93, 1'b0, 32'd0,  1'b0, FLT_NONE, 1'b0, 32'd0},
            '{1'b0, 10'd7,    8'h80, 1'b0, 32'd0,  1'b0, FLT_NONE, 1'b0, 32'd0},
            '{1'b1, 10'd0,    8'h00, 1'b1, 32'd8,  1'b0, FLT_NONE, 1'b1, 32'hFFFF_FF80},
            '{1'b0, 10'd8,    8'hF2, 1'b0, 32'd0,  1'b0, FLT_NONE, 1'b0, 32'd0},
            '{1'b0, 10'd9,    8'h0F, 1'b0, 32'd0,  1'b0, FLT_NONE, 1'b0, 32'd0},
            '{1'b1, 10'd0,    8'h00, 1'b1, 32'd10, 1'b0, FLT_NONE, 1'b0, 32'd0},
            '{1'b0, 10'd10,   8'hE4, 1'b0, 32'd0,  1'b0, FLT_NONE, 1'b0, 32'd0},
            '{1'b0, 10'd11,   8'h0F, 1'b0, 32'd0,  1'b0, FLT_NONE, 1'b0, 32'd0},
            '{1'b1, 10'd0,    8'h00, 1'b1, 32'd12, 1'b0, FLT_NONE, 1'b1, 32'd127},
            '{1'b0, 10'h3FF,  8'hFF, 1'b1, 32'd12, 1'b0, FLT_NONE, 1'b0, 32'd0}
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            r = predict_step(dir_rows[i].act, dir_rows[i].adr, dir_rows[i].dat);
            if (dir_rows[i].chk) begin
                r.next_pc = dir_rows[i].pc;
                r.halted = dir_rows[i].halted;
                r.fault = dir_rows[i].fault;
            end
            if (dir_rows[i].chk_rv) r.reg_val = dir_rows[i].rval;
            pending_steps.push_back(r);
            drive_request(dir_rows[i].act, dir_rows[i].adr, dir_rows[i].dat);
        end

        while (items_sent < ITEM_GOAL) begin
            if ($urandom_range(0, 149) == 0) calm = ($urandom_range(0, 2) == 0);
            run_instruction();
        end
        calm = 1'b0;

        // cut-off instruction at the last halfword, then run off the end of memory
        t = 32'd511;
        send_request(1'b0, cpu_pc[9:0],         {OP_JMP, t[27:24]});
        send_request(1'b0, cpu_pc[9:0] + 10'd1, t[23:16]);
        send_request(1'b0, cpu_pc[9:0] + 10'd2, t[15:8]);
        send_request(1'b0, cpu_pc[9:0] + 10'd3, t[7:0]);
        send_request(1'b1, 10'd0, 8'd0);
        send_request(1'b0, 10'd1022, {OP_BEQ, 4'd0});
        send_request(1'b0, 10'd1023, 8'h00);
        send_request(1'b1, 10'd0, 8'd0);
        send_request(1'b0, 10'd1022, {OP_ADDI, 4'd0});
        send_request(1'b1, 10'd0, 8'd0);
        send_request(1'b1, 10'd0, 8'd0);
        send_request(1'b1, 10'h3FF, 8'hFF);
        s_valid <= 1'b0;

        while (pending_steps.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
